// File: design/fdes_pkg.sv
// Shared widths, codes and constants of the FAT32 deleted-entry scanner.
package fdes_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned CLUS_W    = 32;
  localparam int unsigned SECT_W    = 32;
  localparam int unsigned COUNT_W   = 24;
  localparam int unsigned LNAME_W   = 6;
  localparam int unsigned KIND_W    = 2;

  localparam int unsigned SPC_W     = 8;
  localparam int unsigned BASE_W    = 32;
  localparam int unsigned ROOT_W    = 28;
  localparam int unsigned FATCNT_W  = 17;
  localparam int unsigned EOC_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Bitmap row width of the visited-cluster memory.
  localparam int unsigned ROW_W     = 32;

  localparam int unsigned DEF_MAX_CLUSTERS = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_SPC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FATCNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EOC    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUBDIR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

  localparam logic [BYTE_W-1:0]  NAME_END     = 8'h00;
  localparam logic [BYTE_W-1:0]  NAME_DELETED = 8'hE5;
  localparam logic [BYTE_W-1:0]  ATTR_LFN     = 8'h0F;
  localparam logic [SIZE_W-1:0]  SIZE_ONES    = 32'hFFFF_FFFF;
  localparam logic [CLUS_W-1:0]  EOC_FIXED    = 32'h0FFF_FFF8;
  localparam logic [SIZE_W-1:0]  SECTOR_ROUND = 32'd511;
  localparam int unsigned        SECTOR_SHIFT = 9;
  localparam logic [LNAME_W-1:0] LNAME_MAX    = 6'd63;

  localparam logic [SPC_W-1:0]  RST_SPC    = 8'd1;
  localparam logic [BASE_W-1:0] RST_BASE   = 32'd0;
  localparam logic [ROOT_W-1:0] RST_ROOT   = 28'd2;
  localparam logic [FATCNT_W-1:0] RST_FATCNT = 17'd0;
  localparam logic [EOC_W-1:0]  RST_EOC    = 32'h0FFF_FFFF;

endpackage

// File: design/fdes_if.sv
// Request channel interfaces: directory entries in, scan results out.
interface fdes_in_if import fdes_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cluster_start;
  logic [BYTE_W-1:0]   name_first_byte;
  logic [BYTE_W-1:0]   attribute;
  logic [SIZE_W-1:0]   file_size;
  logic [HALF_W-1:0]   cluster_high;
  logic [HALF_W-1:0]   cluster_low;

  modport source (
    output valid, cluster_start, name_first_byte, attribute, file_size,
           cluster_high, cluster_low,
    input  ready
  );
  modport sink (
    input  valid, cluster_start, name_first_byte, attribute, file_size,
           cluster_high, cluster_low,
    output ready
  );
endinterface

interface fdes_out_if import fdes_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   entry_kind;
  logic [CLUS_W-1:0]   found_cluster;
  logic [SECT_W-1:0]   start_sector;
  logic [COUNT_W-1:0]  sector_count;
  logic [SIZE_W-1:0]   deleted_size;
  logic [LNAME_W-1:0]  long_name_entries;
  logic                extent_valid;

  modport source (
    output valid, entry_kind, found_cluster, start_sector, sector_count,
           deleted_size, long_name_entries, extent_valid,
    input  ready
  );
  modport sink (
    input  valid, entry_kind, found_cluster, start_sector, sector_count,
           deleted_size, long_name_entries, extent_valid,
    output ready
  );
endinterface

// File: design/fdes_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fdes_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/fat32_deleted_entry_scanner.sv
// Top level of the FAT32 deleted-entry scanner: entry classification and visited-cluster bitmap.
// Takes one directory entry per cycle and returns one result per entry, registered in stage
// one and then in the result register, in order; a waiting result does not stop the next
// entry from being taken unless stage one and the result register are both full and the
// result is not being drained. The rate is set by the visited-cluster bitmap, a RAM of
// MAX_CLUSTERS/32 rows of 32 bits with one read and one write port: a subdirectory entry
// reads its row in the cycle it is accepted and writes it back when it leaves stage one,
// and the last written row is forwarded to the following entry. After reset the block
// clears the bitmap, one row per cycle, with in_ch.ready low; configuration writes are
// taken during that time.
module fat32_deleted_entry_scanner import fdes_pkg::*; #(
  parameter int unsigned MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fdes_in_if.sink              in_ch,
  fdes_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int unsigned ROWS   = (MAX_CLUSTERS + ROW_W - 1) / ROW_W;
  localparam int unsigned ROW_AW = $clog2(ROWS);
  localparam int unsigned BIT_W  = $clog2(ROW_W);
  localparam logic [CLUS_W:0] MAX_CLUS_EXT = (CLUS_W+1)'(MAX_CLUSTERS);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  // Configuration registers.
  logic [SPC_W-1:0]    spc_r;
  logic [BASE_W-1:0]   base_r;
  logic [ROOT_W-1:0]   root_r;
  logic [FATCNT_W-1:0] fatcnt_r;
  logic [EOC_W-1:0]    eoc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r    <= RST_SPC;
      base_r   <= RST_BASE;
      root_r   <= RST_ROOT;
      fatcnt_r <= RST_FATCNT;
      eoc_r    <= RST_EOC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPC:    spc_r    <= cfg_wdata[SPC_W-1:0];
        CFG_BASE:   base_r   <= cfg_wdata[BASE_W-1:0];
        CFG_ROOT:   root_r   <= cfg_wdata[ROOT_W-1:0];
        CFG_FATCNT: fatcnt_r <= cfg_wdata[FATCNT_W-1:0];
        CFG_EOC:    eoc_r    <= cfg_wdata[EOC_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic                clr_active_r;
  logic [ROW_AW-1:0]   clr_addr_r;
  logic                end_seen_r, end_seen_nxt;
  logic [LNAME_W-1:0]  lnr_r, lnr_nxt;
  logic                s1_valid_r;
  logic                out_valid_r;
  logic                lw_valid_r;

  // Stage-one payload.
  logic [KIND_W-1:0]   s1_kind_r;
  logic                s1_dir_r;
  logic [ROW_AW-1:0]   s1_row_r;
  logic [BIT_W-1:0]    s1_bit_r;
  logic [CLUS_W-1:0]   s1_clus_r;
  logic [LNAME_W-1:0]  s1_lnames_r;
  logic [SIZE_W-1:0]   s1_size_r;
  logic [COUNT_W-1:0]  s1_count_r;
  logic [SECT_W-1:0]   s1_pclus_r;
  logic [SECT_W-1:0]   s1_proot_r;
  logic                s1_ext_r;

  // Last bitmap row written, for forwarding.
  logic [ROW_AW-1:0]   lw_row_r;
  logic [ROW_W-1:0]    lw_data_r;

  // Result register.
  logic [KIND_W-1:0]   out_kind_r;
  logic [CLUS_W-1:0]   out_found_r;
  logic [SECT_W-1:0]   out_sector_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic [LNAME_W-1:0]  out_lnames_r;
  logic                out_ext_r;

  // Handshake.
  logic in_fire, s1_adv, s1_fire;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_ch.ready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Stage zero: classify the entry and update the per-cluster state.
  logic                es_eff;
  logic [LNAME_W-1:0]  lr_eff;
  logic [CLUS_W-1:0]   clus_raw, clus;
  logic                size_dir, is_end, is_long, is_short, dir_cand, is_del, ext;
  logic [SIZE_W-1:0]   size_round;
  logic [ROW_AW-1:0]   rd_row;
  logic [KIND_W-1:0]   kind_pre;

  always_comb begin
    es_eff   = in_ch.cluster_start ? 1'b0 : end_seen_r;
    lr_eff   = in_ch.cluster_start ? '0 : lnr_r;
    clus_raw = {in_ch.cluster_high, in_ch.cluster_low};
    clus     = (clus_raw == eoc_r || clus_raw == EOC_FIXED) ? '0 : clus_raw;
    size_dir = (in_ch.file_size == '0) || (in_ch.file_size == SIZE_ONES);
    is_end   = !es_eff && (in_ch.name_first_byte == NAME_END);
    is_long  = !es_eff && !is_end && (in_ch.attribute == ATTR_LFN);
    is_short = !es_eff && !is_end && (in_ch.attribute != ATTR_LFN);
    dir_cand = is_short && size_dir && (clus != '0)
               && (clus < CLUS_W'(fatcnt_r)) && ({1'b0, clus} < MAX_CLUS_EXT);
    is_del   = is_short && !size_dir && (in_ch.name_first_byte == NAME_DELETED);
    ext      = is_del && (clus != '0);
    size_round = in_ch.file_size + SECTOR_ROUND;
    rd_row   = dir_cand ? clus[ROW_AW+BIT_W-1 -: ROW_AW] : '0;
    kind_pre = is_end ? KIND_END : (is_del ? KIND_DELETED : KIND_IGNORED);

    end_seen_nxt = is_end ? 1'b1 : es_eff;
    if (is_long) begin
      lnr_nxt = (lr_eff != LNAME_MAX) ? lr_eff + 1'b1 : lr_eff;
    end else if (is_short) begin
      lnr_nxt = '0;
    end else begin
      lnr_nxt = lr_eff;
    end
  end

  // Stage one: finish the bitmap read-modify-write and the sector arithmetic.
  logic [ROW_W-1:0]   ram_rdata, row_cur, row_new;
  logic               seen, dir_hit, reported;
  logic               map_we;
  logic [ROW_AW-1:0]  map_waddr;
  logic [ROW_W-1:0]   map_wdata;
  logic [SECT_W-1:0]  sector;

  always_comb begin
    row_cur   = (lw_valid_r && lw_row_r == s1_row_r) ? lw_data_r : ram_rdata;
    seen      = row_cur[s1_bit_r];
    dir_hit   = s1_dir_r && !seen;
    reported  = dir_hit || (s1_kind_r == KIND_DELETED);
    row_new   = row_cur | (ROW_W'(1) << s1_bit_r);
    map_we    = clr_active_r || (s1_fire && dir_hit);
    map_waddr = clr_active_r ? clr_addr_r : s1_row_r;
    map_wdata = clr_active_r ? '0 : row_new;
    sector    = s1_pclus_r + base_r - s1_proot_r;
  end

  fdes_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_visited (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_fire),
    .raddr (rd_row),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      end_seen_r   <= 1'b0;
      lnr_r        <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      lw_valid_r   <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ROW) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_fire) begin
        end_seen_r <= end_seen_nxt;
        lnr_r      <= lnr_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire && dir_hit) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r   <= kind_pre;
      s1_dir_r    <= dir_cand;
      s1_row_r    <= rd_row;
      s1_bit_r    <= clus[BIT_W-1:0];
      s1_clus_r   <= clus;
      s1_lnames_r <= (dir_cand || is_del) ? lr_eff : '0;
      s1_size_r   <= is_del ? in_ch.file_size : '0;
      s1_count_r  <= ext ? COUNT_W'(size_round >> SECTOR_SHIFT) : '0;
      s1_pclus_r  <= clus * SECT_W'(spc_r);
      s1_proot_r  <= SECT_W'(root_r) * SECT_W'(spc_r);
      s1_ext_r    <= ext;
    end
    if (s1_fire && dir_hit) begin
      lw_row_r  <= s1_row_r;
      lw_data_r <= row_new;
    end
    if (s1_fire) begin
      out_kind_r   <= dir_hit ? KIND_SUBDIR : s1_kind_r;
      out_found_r  <= reported ? s1_clus_r : '0;
      out_lnames_r <= reported ? s1_lnames_r : '0;
      out_sector_r <= s1_ext_r ? sector : '0;
      out_count_r  <= s1_count_r;
      out_size_r   <= s1_size_r;
      out_ext_r    <= s1_ext_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.entry_kind        = out_kind_r;
  assign out_ch.found_cluster     = out_found_r;
  assign out_ch.start_sector      = out_sector_r;
  assign out_ch.sector_count      = out_count_r;
  assign out_ch.deleted_size      = out_size_r;
  assign out_ch.long_name_entries = out_lnames_r;
  assign out_ch.extent_valid      = out_ext_r;

endmodule
